FILE: design/sbe_pkg.sv
// shared types and constants of the stack bytecode executor
// no dependencies; compiled first
package sbe_pkg;

    localparam int STACK_WORDS_DEF    = 256;
    localparam int GLOBAL_WORDS_DEF   = 256;
    localparam int PROG_ADDR_BITS_DEF = 16;

    typedef enum logic [4:0] {
        OP_RET     = 5'd0,
        OP_ECALL   = 5'd1,
        OP_GSTORE  = 5'd2,
        OP_LOAD    = 5'd3,
        OP_PUSHI   = 5'd4,
        OP_NE      = 5'd5,
        OP_EQ      = 5'd6,
        OP_GT      = 5'd7,
        OP_GE      = 5'd8,
        OP_LT      = 5'd9,
        OP_LE      = 5'd10,
        OP_JMP     = 5'd11,
        OP_JMPZ    = 5'd12,
        OP_MOD     = 5'd13,
        OP_ADD     = 5'd14,
        OP_SUB     = 5'd15,
        OP_MUL     = 5'd16,
        OP_DIV     = 5'd17
    } opcode_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
    localparam logic [2:0] ERR_GLOBAL    = 3'd4;

    localparam logic [1:0] KIND_INT       = 2'd0;
    localparam logic [1:0] KIND_INT_NL    = 2'd1;
    localparam logic [1:0] KIND_STRING    = 2'd2;
    localparam logic [1:0] KIND_STRING_NL = 2'd3;

    localparam logic [31:0] EXT_READ       = 32'd0;
    localparam logic [31:0] EXT_INT        = 32'd1;
    localparam logic [31:0] EXT_STRING     = 32'd2;
    localparam logic [31:0] EXT_STRING_NL  = 32'd3;
    localparam logic [31:0] EXT_INT_NL     = 32'd4;

    localparam logic [4:0] PC_STEP_LONG = 5'd5;

    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_TOS
    } rd_sel_t;

    typedef struct packed {
        logic    in_take;
        rd_sel_t rd_sel;
        logic    lat_a;
        logic    lat_b;
        logic    exec;
        logic    div_start;
        logic    div_cap;
        logic    gload_cap;
        logic    commit;
        logic    tos_cap;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic need_gload;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

FILE: design/sbe_if.sv
// valid/ready channel interfaces for instruction beats and result beats
// no dependencies
interface sbe_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         opcode;
    logic signed [31:0] immediate;
    logic signed [31:0] read_value;

    modport source (output valid, output opcode, output immediate, output read_value,
                    input ready);
    modport sink (input valid, input opcode, input immediate, input read_value,
                  output ready);
endinterface

interface sbe_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        next_pc;
    logic               halted;
    logic               emit_valid;
    logic [1:0]         emit_kind;
    logic signed [31:0] emit_value;
    logic               read_used;
    logic [2:0]         error_code;
    logic [8:0]         stack_depth;
    logic signed [31:0] top_of_stack;

    modport source (output valid, output next_pc, output halted, output emit_valid,
                    output emit_kind, output emit_value, output read_used,
                    output error_code, output stack_depth, output top_of_stack,
                    input ready);
    modport sink (input valid, input next_pc, input halted, input emit_valid,
                  input emit_kind, input emit_value, input read_used,
                  input error_code, input stack_depth, input top_of_stack,
                  output ready);
endinterface

FILE: design/sbe_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module sbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sbe_div.sv
// iterative signed 32-bit divider, one quotient bit per cycle
// depends on nothing; quotient truncates, remainder follows dividend sign
module sbe_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  logic        want_rem,
    output logic        done,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        want_rem_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= '0;
            quo_reg      <= dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_reg      <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_q_reg    <= dividend[31] ^ divisor[31];
            neg_r_reg    <= dividend[31];
            want_rem_reg <= want_rem;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done   = done_reg;
    assign result = want_rem_reg ? (neg_r_reg ? (32'd0 - rem_reg) : rem_reg)
                                 : (neg_q_reg ? (32'd0 - quo_reg) : quo_reg);

endmodule

FILE: design/sbe_ctrl.sv
// sequencing state machine for one instruction at a time
// depends on sbe_pkg
module sbe_ctrl
    import sbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_LATB,
        S_EXEC,
        S_GLOAD,
        S_DIVW,
        S_COMMIT,
        S_TOSRD,
        S_TOSCAP,
        S_OUTW
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_A;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_take = in_valid;
                if (in_valid)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                cmd.rd_sel = RD_A;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.rd_sel = RD_B;
                cmd.lat_a  = 1'b1;
                state_next = S_LATB;
            end
            S_LATB:
            begin
                cmd.lat_b  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
                else if (status.need_gload)
                begin
                    state_next = S_GLOAD;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_GLOAD:
            begin
                cmd.gload_cap = 1'b1;
                state_next    = S_COMMIT;
            end
            S_DIVW:
            begin
                if (status.div_done)
                begin
                    cmd.div_cap = 1'b1;
                    state_next  = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_TOSRD;
            end
            S_TOSRD:
            begin
                cmd.rd_sel = RD_TOS;
                state_next = S_TOSCAP;
            end
            S_TOSCAP:
            begin
                cmd.tos_cap = 1'b1;
                state_next  = S_OUTW;
            end
            S_OUTW:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/sbe_dpath.sv
// datapath: stack and global rams, pc, stack pointer, alu, divider, result register
// depends on sbe_pkg, sbe_if, sbe_ram, sbe_div
module sbe_dpath
    import sbe_pkg::*;
#(
    parameter int STACK_WORDS    = STACK_WORDS_DEF,
    parameter int GLOBAL_WORDS   = GLOBAL_WORDS_DEF,
    parameter int PROG_ADDR_BITS = PROG_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [4:0]  opcode,
    input  logic [31:0] immediate,
    input  logic [31:0] read_value,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    sbe_out_if.source   out_ch
);

    localparam int SAW = $clog2(STACK_WORDS);
    localparam int SPW = $clog2(STACK_WORDS + 1);
    localparam int GAW = (GLOBAL_WORDS > 1) ? $clog2(GLOBAL_WORDS) : 1;
    localparam int PCW = PROG_ADDR_BITS;

    opcode_t          op_reg;
    logic [31:0]      imm_reg;
    logic [31:0]      rdv_reg;
    logic [31:0]      a_reg;
    logic [31:0]      b_reg;
    logic [SPW-1:0]   sp_reg;
    logic [PCW-1:0]   pc_reg;
    logic [15:0]      start_reg;
    logic [31:0]      tos_reg;

    logic [2:0]       err_reg;
    logic [SPW-1:0]   nsp_reg;
    logic             swe_reg;
    logic [SAW-1:0]   swa_reg;
    logic [31:0]      res_reg;
    logic             gwe_reg;
    logic [GAW-1:0]   gwa_reg;
    logic [31:0]      gwd_reg;
    logic [PCW-1:0]   npc_reg;
    logic             halt_reg;
    logic             ev_reg;
    logic [1:0]       ek_reg;
    logic [31:0]      evv_reg;
    logic             ru_reg;

    logic             o_valid_reg;
    logic [15:0]      o_pc_reg;
    logic             o_halt_reg;
    logic             o_ev_reg;
    logic [1:0]       o_ek_reg;
    logic [31:0]      o_evv_reg;
    logic             o_ru_reg;
    logic [2:0]       o_err_reg;
    logic [8:0]       o_depth_reg;
    logic [31:0]      o_tos_reg;

    logic [29:0]      words;
    logic [SPW-1:0]   sp_m1;
    logic [SPW-1:0]   sp_m2;
    logic [SPW-1:0]   base;
    logic             sp_ge1;
    logic             sp_ge2;
    logic             ext_under;
    logic             a_idx_bad;
    logic             b_idx_bad;
    logic [SAW-1:0]   addr_a;
    logic [SAW-1:0]   addr_b;
    logic [SAW-1:0]   stk_raddr;
    logic [31:0]      stk_rdata;
    logic [31:0]      glb_rdata;
    logic [31:0]      mul_res;
    logic             div_done;
    logic [31:0]      div_res;
    logic             is_div;

    logic [2:0]       e_err;
    logic [SPW-1:0]   e_nsp;
    logic             e_swe;
    logic [SAW-1:0]   e_swa;
    logic [31:0]      e_res;
    logic             e_gwe;
    logic [PCW-1:0]   e_npc;
    logic             e_halt;
    logic             e_ev;
    logic [1:0]       e_ek;
    logic [31:0]      e_evv;
    logic             e_ru;

    assign words     = imm_reg[31:2];
    assign sp_m1     = sp_reg - SPW'(1);
    assign sp_m2     = sp_reg - SPW'(2);
    assign base      = sp_reg - SPW'(words) - SPW'(1);
    assign sp_ge1    = (sp_reg != '0);
    assign sp_ge2    = (sp_reg >= SPW'(2));
    assign ext_under = (({1'b0, words} + 31'd1) > 31'(sp_reg));
    assign a_idx_bad = ({2'b00, a_reg[31:2]} >= 32'(GLOBAL_WORDS));
    assign b_idx_bad = ({2'b00, b_reg[31:2]} >= 32'(GLOBAL_WORDS));
    assign mul_res   = a_reg * b_reg;
    assign is_div    = (op_reg == OP_DIV) || (op_reg == OP_MOD);

    // operand fetch addresses: extcall reads the type word and first argument
    always_comb
    begin
        if (op_reg == OP_ECALL)
        begin
            addr_a = base[SAW-1:0];
            addr_b = base[SAW-1:0] + SAW'(1);
        end
        else
        begin
            addr_a = sp_m2[SAW-1:0];
            addr_b = sp_m1[SAW-1:0];
        end
        case (cmd.rd_sel)
            RD_A:    stk_raddr = addr_a;
            RD_B:    stk_raddr = addr_b;
            default: stk_raddr = sp_m1[SAW-1:0];
        endcase
    end

    sbe_ram #(
        .WIDTH (32),
        .DEPTH (STACK_WORDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (cmd.commit & swe_reg),
        .waddr (swa_reg),
        .wdata (res_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    sbe_ram #(
        .WIDTH (32),
        .DEPTH (GLOBAL_WORDS)
    ) u_global_ram (
        .clk   (clk),
        .we    (cmd.commit & gwe_reg),
        .waddr (gwa_reg),
        .wdata (gwd_reg),
        .raddr (b_reg[2 +: GAW]),
        .rdata (glb_rdata)
    );

    sbe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .want_rem (op_reg == OP_MOD),
        .done     (div_done),
        .result   (div_res)
    );

    // instruction decode and execute
    always_comb
    begin
        e_err  = ERR_NONE;
        e_nsp  = sp_reg;
        e_swe  = 1'b0;
        e_swa  = sp_m2[SAW-1:0];
        e_res  = '0;
        e_gwe  = 1'b0;
        e_npc  = pc_reg + PCW'(1);
        e_halt = 1'b0;
        e_ev   = 1'b0;
        e_ek   = KIND_INT;
        e_evv  = '0;
        e_ru   = 1'b0;
        case (op_reg)
            OP_RET:
            begin
                e_halt = 1'b1;
                e_npc  = PCW'(start_reg);
                e_nsp  = '0;
            end
            OP_ECALL:
            begin
                e_npc = pc_reg + PCW'(PC_STEP_LONG);
                if (ext_under)
                begin
                    e_err = ERR_UNDERFLOW;
                end
                else
                begin
                    e_nsp = base;
                    case (a_reg)
                        EXT_READ:
                        begin
                            e_swe = 1'b1;
                            e_swa = base[SAW-1:0];
                            e_res = rdv_reg;
                            e_nsp = base + SPW'(1);
                            e_ru  = 1'b1;
                        end
                        EXT_INT, EXT_INT_NL, EXT_STRING, EXT_STRING_NL:
                        begin
                            e_ev  = 1'b1;
                            e_evv = (words != '0) ? b_reg : 32'd0;
                            case (a_reg)
                                EXT_INT:    e_ek = KIND_INT;
                                EXT_INT_NL: e_ek = KIND_INT_NL;
                                EXT_STRING: e_ek = KIND_STRING;
                                default:    e_ek = KIND_STRING_NL;
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            OP_GSTORE:
            begin
                if (!sp_ge2)
                begin
                    e_err = ERR_UNDERFLOW;
                end
                else if (a_idx_bad)
                begin
                    e_err = ERR_GLOBAL;
                end
                else
                begin
                    e_gwe = 1'b1;
                    e_nsp = sp_m2;
                end
            end
            OP_LOAD:
            begin
                if (!sp_ge1)
                begin
                    e_err = ERR_UNDERFLOW;
                end
                else if (b_idx_bad)
                begin
                    e_err = ERR_GLOBAL;
                end
                else
                begin
                    e_swe = 1'b1;
                    e_swa = sp_m1[SAW-1:0];
                end
            end
            OP_PUSHI:
            begin
                e_npc = pc_reg + PCW'(PC_STEP_LONG);
                if (sp_reg >= SPW'(STACK_WORDS))
                begin
                    e_err = ERR_OVERFLOW;
                end
                else
                begin
                    e_swe = 1'b1;
                    e_swa = sp_reg[SAW-1:0];
                    e_res = imm_reg;
                    e_nsp = sp_reg + SPW'(1);
                end
            end
            OP_JMP:
            begin
                e_npc = PCW'(imm_reg);
            end
            OP_JMPZ:
            begin
                e_npc = pc_reg + PCW'(PC_STEP_LONG);
                if (!sp_ge1)
                begin
                    e_err = ERR_UNDERFLOW;
                end
                else
                begin
                    e_nsp = sp_m1;
                    if (b_reg == 32'd0)
                    begin
                        e_npc = PCW'(imm_reg);
                    end
                end
            end
            OP_NE, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
            OP_MOD, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (!sp_ge2)
                begin
                    e_err = ERR_UNDERFLOW;
                end
                else if (is_div && (b_reg == 32'd0))
                begin
                    e_err = ERR_DIV_ZERO;
                end
                else
                begin
                    e_swe = 1'b1;
                    e_nsp = sp_m1;
                    case (op_reg)
                        OP_NE:   e_res = 32'(a_reg != b_reg);
                        OP_EQ:   e_res = 32'(a_reg == b_reg);
                        OP_GT:   e_res = 32'($signed(a_reg) > $signed(b_reg));
                        OP_GE:   e_res = 32'($signed(a_reg) >= $signed(b_reg));
                        OP_LT:   e_res = 32'($signed(a_reg) < $signed(b_reg));
                        OP_LE:   e_res = 32'($signed(a_reg) <= $signed(b_reg));
                        OP_ADD:  e_res = a_reg + b_reg;
                        OP_SUB:  e_res = a_reg - b_reg;
                        OP_MUL:  e_res = mul_res;
                        default: e_res = '0;
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.need_div   = is_div && sp_ge2 && (b_reg != 32'd0);
    assign status.need_gload = (op_reg == OP_LOAD) && sp_ge1 && !b_idx_bad;
    assign status.div_done   = div_done;
    assign status.out_free   = !o_valid_reg || out_ch.ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg      <= '0;
            pc_reg      <= '0;
            start_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                sp_reg <= nsp_reg;
                pc_reg <= npc_reg;
            end
            if (cmd.out_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            op_reg  <= opcode_t'(opcode);
            imm_reg <= immediate;
            rdv_reg <= read_value;
        end
        if (cmd.lat_a)
        begin
            a_reg <= stk_rdata;
        end
        if (cmd.lat_b)
        begin
            b_reg <= stk_rdata;
        end
        if (cmd.exec)
        begin
            err_reg  <= e_err;
            nsp_reg  <= e_nsp;
            swe_reg  <= e_swe;
            swa_reg  <= e_swa;
            res_reg  <= e_res;
            gwe_reg  <= e_gwe;
            gwa_reg  <= a_reg[2 +: GAW];
            gwd_reg  <= b_reg;
            npc_reg  <= e_npc;
            halt_reg <= e_halt;
            ev_reg   <= e_ev;
            ek_reg   <= e_ek;
            evv_reg  <= e_evv;
            ru_reg   <= e_ru;
        end
        else if (cmd.gload_cap)
        begin
            res_reg <= glb_rdata;
        end
        else if (cmd.div_cap)
        begin
            res_reg <= div_res;
        end
        if (cmd.tos_cap)
        begin
            tos_reg <= (sp_reg != '0) ? stk_rdata : 32'd0;
        end
        if (cmd.out_load)
        begin
            o_pc_reg    <= 16'(pc_reg);
            o_halt_reg  <= halt_reg;
            o_ev_reg    <= ev_reg;
            o_ek_reg    <= ek_reg;
            o_evv_reg   <= evv_reg;
            o_ru_reg    <= ru_reg;
            o_err_reg   <= err_reg;
            o_depth_reg <= 9'(sp_reg);
            o_tos_reg   <= tos_reg;
        end
    end

    assign out_ch.valid        = o_valid_reg;
    assign out_ch.next_pc      = o_pc_reg;
    assign out_ch.halted       = o_halt_reg;
    assign out_ch.emit_valid   = o_ev_reg;
    assign out_ch.emit_kind    = o_ek_reg;
    assign out_ch.emit_value   = o_evv_reg;
    assign out_ch.read_used    = o_ru_reg;
    assign out_ch.error_code   = o_err_reg;
    assign out_ch.stack_depth  = o_depth_reg;
    assign out_ch.top_of_stack = o_tos_reg;

endmodule

FILE: design/stack_bytecode_executor.sv
// stack bytecode executor: one instruction beat in, one result beat out
// sequence: operand reads, execute, commit and top-of-stack read; load adds a global
//   ram read, div and mod wait for the 32-step divider; one instruction in flight
// a new beat is taken only after the previous result is loaded into the output register,
//   which waits while the result before it is not yet taken
// reset: stack pointer, pc and start address clear, rams hold undefined data
// depends on sbe_pkg, sbe_if, sbe_ctrl, sbe_dpath
module stack_bytecode_executor
    import sbe_pkg::*;
#(
    parameter int STACK_WORDS    = STACK_WORDS_DEF,
    parameter int GLOBAL_WORDS   = GLOBAL_WORDS_DEF,
    parameter int PROG_ADDR_BITS = PROG_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    sbe_in_if.sink      in_ch,
    sbe_out_if.source   out_ch,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // command and status bundles between sequencer and datapath
    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    // sequencer: fetch operands, execute, commit, read back top of stack,
    // then park the result beat in the output register
    sbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // datapath: stack and global rams, alu, divider, architectural state
    sbe_dpath #(
        .STACK_WORDS    (STACK_WORDS),
        .GLOBAL_WORDS   (GLOBAL_WORDS),
        .PROG_ADDR_BITS (PROG_ADDR_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (in_ch.opcode),
        .immediate   (in_ch.immediate),
        .read_value  (in_ch.read_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ch      (out_ch)
    );

endmodule

FILE: tb/stack_bytecode_executor_test.sv
// self-checking testbench for the stack bytecode executor
// depends on sbe_pkg, sbe_if and the stack_bytecode_executor rtl
module stack_bytecode_executor_test;
    import sbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one instruction beat as queued for the driver
    typedef struct {
        logic [4:0]  opcode;
        logic [31:0] immediate;
        logic [31:0] read_value;
    } instr_t;

    // one result beat as the executor should report it
    typedef struct {
        logic [15:0] next_pc;
        logic        halted;
        logic        emit_valid;
        logic [1:0]  emit_kind;
        logic [31:0] emit_value;
        logic        read_used;
        logic [2:0]  error_code;
        logic [8:0]  stack_depth;
        logic [31:0] top_of_stack;
    } outcome_t;

    localparam int NUM_STACK  = 256;
    localparam int NUM_GLOBAL = 256;
    localparam int TARGET_ITEMS = 1150;
    localparam int PHASES = 5;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [4:0]  OP_UNDEF_TOP = 5'd31;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    sbe_in_if  in_ch ();
    sbe_out_if out_ch ();

    stack_bytecode_executor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // instruction beats waiting for the driver, result beats waiting for the monitor
    instr_t   pending_instrs[$];
    outcome_t expected_outcomes[$];

    // shadow machine state, advanced as instructions are queued
    logic [31:0] shadow_stack [NUM_STACK];
    logic [31:0] shadow_globals [NUM_GLOBAL];
    bit          global_written [NUM_GLOBAL];
    int          written_idx[$];
    int          shadow_sp;
    logic [15:0] shadow_pc;
    logic [15:0] shadow_start;

    int  issued_count;
    int  mismatch_count;
    bit  in_fire;
    bit  out_fire;
    bit  hold_off_req;
    bit  hold_off_done;
    int  hold_off_left;
    int  send_gap;
    int  recv_gap;
    bit  no_gap_mode;
    int  idle_cycles;

    // clock; the single reset at start is driven by the stimulus block
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // gap length: mostly none, sometimes short, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_mode || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // operand values biased toward the corners of 32-bit arithmetic
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return INT_MIN;
            4: return INT_MAX;
            5: return $urandom_range(0, 20);
            6: return -$urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    // global byte address: usually in range with random low bits, sometimes out of range
    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return INT_MIN | $urandom;
        else if (r == 1)
            return (NUM_GLOBAL * 4) + $urandom_range(0, 4000);
        else
            return ($urandom_range(0, NUM_GLOBAL - 1) * 4) + $urandom_range(0, 3);
    endfunction

    // an address that is safe to load: a stored word, or out of range if none yet
    function automatic logic [31:0] safe_load_addr();
        if (written_idx.size() == 0)
            return INT_MIN;
        return (written_idx[$urandom_range(0, written_idx.size() - 1)] * 4)
               + $urandom_range(0, 3);
    endfunction

    // advance the shadow machine by one instruction and record the result it should give
    task automatic predict_outcome(input instr_t ins);
        outcome_t    o;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] idx;
        logic [31:0] ext_type;
        longint      words;
        int          base;
        o = '{default: '0};
        o.next_pc = shadow_pc + 16'd1;
        r = '0;
        case (ins.opcode)
            OP_RET:
            begin
                o.halted = 1'b1;
                o.next_pc = shadow_start;
                shadow_sp = 0;
            end
            OP_ECALL:
            begin
                words = longint'(ins.immediate >> 2);
                o.next_pc = shadow_pc + 16'd5;
                if (words + 1 > shadow_sp)
                    o.error_code = ERR_UNDERFLOW;
                else
                begin
                    base = shadow_sp - int'(words) - 1;
                    ext_type = shadow_stack[base];
                    a = (words != 0) ? shadow_stack[base + 1] : 32'd0;
                    shadow_sp = base;
                    // types 1..4 emit the first argument, read pushes, others just pop
                    case (ext_type)
                        EXT_READ:
                        begin
                            shadow_stack[shadow_sp] = ins.read_value;
                            shadow_sp++;
                            o.read_used = 1'b1;
                        end
                        EXT_INT:
                        begin
                            o.emit_valid = 1'b1; o.emit_kind = KIND_INT; o.emit_value = a;
                        end
                        EXT_INT_NL:
                        begin
                            o.emit_valid = 1'b1; o.emit_kind = KIND_INT_NL; o.emit_value = a;
                        end
                        EXT_STRING:
                        begin
                            o.emit_valid = 1'b1; o.emit_kind = KIND_STRING; o.emit_value = a;
                        end
                        EXT_STRING_NL:
                        begin
                            o.emit_valid = 1'b1; o.emit_kind = KIND_STRING_NL;
                            o.emit_value = a;
                        end
                        default: ;
                    endcase
                end
            end
            OP_GSTORE:
            begin
                if (shadow_sp < 2)
                    o.error_code = ERR_UNDERFLOW;
                else
                begin
                    idx = shadow_stack[shadow_sp - 2] >> 2;
                    if (idx >= NUM_GLOBAL)
                        o.error_code = ERR_GLOBAL;
                    else
                    begin
                        shadow_globals[idx] = shadow_stack[shadow_sp - 1];
                        if (!global_written[idx])
                            written_idx.push_back(int'(idx));
                        global_written[idx] = 1'b1;
                        shadow_sp -= 2;
                    end
                end
            end
            OP_LOAD:
            begin
                if (shadow_sp < 1)
                    o.error_code = ERR_UNDERFLOW;
                else
                begin
                    idx = shadow_stack[shadow_sp - 1] >> 2;
                    if (idx >= NUM_GLOBAL)
                        o.error_code = ERR_GLOBAL;
                    else
                        shadow_stack[shadow_sp - 1] = shadow_globals[idx];
                end
            end
            OP_PUSHI:
            begin
                o.next_pc = shadow_pc + 16'd5;
                if (shadow_sp >= NUM_STACK)
                    o.error_code = ERR_OVERFLOW;
                else
                begin
                    shadow_stack[shadow_sp] = ins.immediate;
                    shadow_sp++;
                end
            end
            OP_JMP:
                o.next_pc = ins.immediate[15:0];
            OP_JMPZ:
            begin
                o.next_pc = shadow_pc + 16'd5;
                if (shadow_sp < 1)
                    o.error_code = ERR_UNDERFLOW;
                else
                begin
                    shadow_sp--;
                    if (shadow_stack[shadow_sp] == 32'd0)
                        o.next_pc = ins.immediate[15:0];
                end
            end
            OP_NE, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE,
            OP_MOD, OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (shadow_sp < 2)
                    o.error_code = ERR_UNDERFLOW;
                else
                begin
                    a = shadow_stack[shadow_sp - 2];
                    b = shadow_stack[shadow_sp - 1];
                    case (ins.opcode)
                        OP_NE: r = {31'd0, a != b};
                        OP_EQ: r = {31'd0, a == b};
                        OP_GT: r = {31'd0, $signed(a) > $signed(b)};
                        OP_GE: r = {31'd0, $signed(a) >= $signed(b)};
                        OP_LT: r = {31'd0, $signed(a) < $signed(b)};
                        OP_LE: r = {31'd0, $signed(a) <= $signed(b)};
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV, OP_MOD:
                        begin
                            // divide by -1 handled apart: the most negative value wraps
                            if (b == 32'd0)
                                o.error_code = ERR_DIV_ZERO;
                            else if (b == 32'hFFFF_FFFF)
                                r = (ins.opcode == OP_DIV) ? (32'd0 - a) : 32'd0;
                            else if (ins.opcode == OP_DIV)
                                r = $signed(a) / $signed(b);
                            else
                                r = $signed(a) % $signed(b);
                        end
                        default: ;
                    endcase
                    if (o.error_code == ERR_NONE)
                    begin
                        shadow_stack[shadow_sp - 2] = r;
                        shadow_sp--;
                    end
                end
            end
            default: ;
        endcase
        shadow_pc = o.next_pc;
        o.stack_depth = shadow_sp[8:0];
        o.top_of_stack = (shadow_sp != 0) ? shadow_stack[shadow_sp - 1] : 32'd0;
        expected_outcomes.push_back(o);
    endtask

    // queue one instruction; a load is preceded by a safe address when the top is unwritten
    task automatic issue(input logic [4:0] op, input logic [31:0] imm);
        instr_t      ins;
        logic [31:0] idx;
        if (op == OP_LOAD && shadow_sp >= 1)
        begin
            idx = shadow_stack[shadow_sp - 1] >> 2;
            if (idx < NUM_GLOBAL && !global_written[idx])
            begin
                if (shadow_sp >= NUM_STACK)
                    issue(OP_RET, $urandom);
                issue(OP_PUSHI, safe_load_addr());
            end
        end
        ins.opcode = op;
        ins.immediate = imm;
        ins.read_value = $urandom;
        pending_instrs.push_back(ins);
        predict_outcome(ins);
        issued_count++;
    endtask

    // extcall with its type word and arguments pushed first
    task automatic issue_extcall();
        int n;
        int i;
        logic [31:0] ext_type;
        n = $urandom_range(0, 3);
        ext_type = ($urandom_range(0, 5) == 0) ? pick_value() : $urandom_range(0, 4);
        issue(OP_PUSHI, ext_type);
        for (i = 0; i < n; i++)
            issue(OP_PUSHI, pick_value());
        // sometimes ask for more words than were pushed to provoke underflow
        if ($urandom_range(0, 9) == 0)
            issue(OP_ECALL, $urandom);
        else
            issue(OP_ECALL, (n * 4) + $urandom_range(0, 3));
    endtask

    // one well-formed sequence with random content, or a noise instruction
    task automatic issue_random_sequence();
        logic [31:0] addr;
        int kind;
        if (shadow_sp > 180 && $urandom_range(0, 3) == 0)
        begin
            issue(OP_RET, $urandom);
            return;
        end
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1, 2, 3, 4:
            begin
                issue(OP_PUSHI, pick_value());
                issue(OP_PUSHI, pick_value());
                issue(5'($urandom_range(OP_NE, OP_LE)), $urandom);
            end
            5, 6, 7, 8:
            begin
                issue(OP_PUSHI, pick_value());
                issue(OP_PUSHI, pick_value());
                issue(5'($urandom_range(OP_MOD, OP_DIV)), $urandom);
            end
            9, 10:
            begin
                issue(OP_PUSHI, pick_addr());
                issue(OP_PUSHI, pick_value());
                issue(OP_GSTORE, $urandom);
            end
            11, 12:
            begin
                addr = ($urandom_range(0, 3) == 0) ? pick_addr() : safe_load_addr();
                issue(OP_PUSHI, addr);
                issue(OP_LOAD, $urandom);
            end
            13, 14:
                issue_extcall();
            15:
            begin
                issue(OP_PUSHI, ($urandom_range(0, 1) == 0) ? 32'd0 : pick_value());
                issue(OP_JMPZ, $urandom);
            end
            16:
                issue(OP_JMP, $urandom);
            17:
                issue(OP_RET, $urandom);
            default:
                // noise: any opcode code including the undefined ones
                issue(5'($urandom_range(0, 31)), $urandom);
        endcase
    endtask

    // short directed run over the corners
    task automatic issue_directed();
        issue(OP_ADD, 32'd0);
        issue(OP_PUSHI, INT_MIN);
        issue(OP_PUSHI, 32'hFFFF_FFFF);
        issue(OP_DIV, 32'd0);
        issue(OP_PUSHI, 32'hFFFF_FFFF);
        issue(OP_MOD, 32'd0);
        issue(OP_PUSHI, 32'd0);
        issue(OP_DIV, 32'd0);
        issue(OP_MOD, 32'd0);
        issue(OP_RET, 32'd0);
        issue(OP_PUSHI, 32'd15);
        issue(OP_PUSHI, INT_MAX);
        issue(OP_GSTORE, 32'd0);
        issue(OP_PUSHI, 32'd12);
        issue(OP_LOAD, 32'd0);
        issue(OP_PUSHI, 32'hFFFF_FFFC);
        issue(OP_LOAD, 32'd0);
        issue(OP_PUSHI, EXT_READ);
        issue(OP_ECALL, 32'd0);
        issue(OP_PUSHI, EXT_INT_NL);
        issue(OP_PUSHI, 32'd42);
        issue(OP_ECALL, 32'd7);
        issue(OP_JMPZ, 32'hFFFF_FFFF);
        issue(OP_JMP, 32'hFFFF_FFFF);
        issue(OP_UNDEF_TOP, INT_MIN);
        issue(OP_SUB, 32'd0);
        issue(OP_MUL, 32'd0);
    endtask

    // wait until every queued beat went in and every result came back, then let it settle
    task automatic drain();
        wait (pending_instrs.size() == 0 && expected_outcomes.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write while the block is idle
    task automatic write_start(input logic [15:0] addr);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= addr;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        shadow_start = addr;
    endtask

    // stimulus: phases of random sequences, each after a write of its start address
    initial
    begin
        int phase;
        int phase_goal;
        int k;
        logic [15:0] starts [PHASES];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        hold_off_req = 1'b0;
        issued_count = 0;
        shadow_sp = 0;
        shadow_start = '0;
        shadow_pc = '0;
        foreach (global_written[i])
            global_written[i] = 1'b0;
        starts[0] = 16'h0000;
        starts[1] = 16'hFFFF;
        starts[2] = 16'h1234;
        starts[3] = 16'($urandom);
        starts[4] = 16'h0000;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_start(starts[phase]);
            if (phase == 0)
                issue_directed();
            // long receiver hold-off while the sender keeps offering
            if (phase == 2)
                hold_off_req = 1'b1;
            // one run up to a full stack and past it
            if (phase == 3)
            begin
                issue(OP_RET, 32'd0);
                for (k = 0; k <= NUM_STACK; k++)
                    issue(OP_PUSHI, pick_value());
                issue(OP_ADD, 32'd0);
            end
            phase_goal = (TARGET_ITEMS * (phase + 1)) / PHASES;
            while (issued_count < phase_goal)
                issue_random_sequence();
            drain();
        end
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // handshake sampling at the rising edge
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        out_fire <= rst_n && out_ch.valid && out_ch.ready;
    end

    // instruction driver: holds a beat until taken, then pops the next after a gap
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.opcode = '0;
        in_ch.immediate = '0;
        in_ch.read_value = '0;
        out_ch.ready = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        hold_off_left = 0;
        hold_off_done = 1'b0;
        no_gap_mode = 1'b0;
        mismatch_count = 0;
        idle_cycles = 0;
    end

    always @(negedge clk)
    begin
        instr_t ins;
        if (rst_n && !(in_ch.valid && !in_fire))
        begin
            if (send_gap > 0 || pending_instrs.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_ch.valid <= 1'b0;
            end
            else
            begin
                ins = pending_instrs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.opcode <= ins.opcode;
                in_ch.immediate <= ins.immediate;
                in_ch.read_value <= ins.read_value;
                send_gap = pick_gap();
                // stretches with no idling at all on either side
                if ($urandom_range(0, 99) == 0)
                    no_gap_mode = !no_gap_mode;
            end
        end
    end

    // result side ready, including the one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_ch.ready <= 1'b0;
        end
        else if (hold_off_req && !hold_off_done)
        begin
            hold_off_done = 1'b1;
            hold_off_left = HOLD_OFF_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_gap = pick_gap();
        end
    end

    // result monitor: each beat against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t exp_o;
        outcome_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.next_pc = out_ch.next_pc;
            got.halted = out_ch.halted;
            got.emit_valid = out_ch.emit_valid;
            got.emit_kind = out_ch.emit_kind;
            got.emit_value = out_ch.emit_value;
            got.read_used = out_ch.read_used;
            got.error_code = out_ch.error_code;
            got.stack_depth = out_ch.stack_depth;
            got.top_of_stack = out_ch.top_of_stack;
            if (expected_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: pc=%h err=%0d depth=%0d",
                             got.next_pc, got.error_code, got.stack_depth);
            end
            else
            begin
                exp_o = expected_outcomes.pop_front();
                if (got.next_pc !== exp_o.next_pc || got.halted !== exp_o.halted
                    || got.emit_valid !== exp_o.emit_valid
                    || got.emit_kind !== exp_o.emit_kind
                    || got.emit_value !== exp_o.emit_value
                    || got.read_used !== exp_o.read_used
                    || got.error_code !== exp_o.error_code
                    || got.stack_depth !== exp_o.stack_depth
                    || got.top_of_stack !== exp_o.top_of_stack)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch exp: pc=%h h=%b ev=%b ek=%0d evv=%h",
                                 exp_o.next_pc, exp_o.halted, exp_o.emit_valid,
                                 exp_o.emit_kind, exp_o.emit_value);
                        $display("              ru=%b err=%0d d=%0d tos=%h",
                                 exp_o.read_used, exp_o.error_code,
                                 exp_o.stack_depth, exp_o.top_of_stack);
                        $display("         got: pc=%h h=%b ev=%b ek=%0d evv=%h",
                                 got.next_pc, got.halted, got.emit_valid,
                                 got.emit_kind, got.emit_value);
                        $display("              ru=%b err=%0d d=%0d tos=%h",
                                 got.read_used, got.error_code,
                                 got.stack_depth, got.top_of_stack);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (in_fire || out_fire)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
